// ===== rtl/core/kpd_pkg.sv =====
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types and constants of the keypad scanner: row patterns, key map,
// register indexes and the lane and result records.
// ----------------------------------------------------------------------------
package kpd_pkg;

  localparam int unsigned NumCols = 5;
  localparam int unsigned NumRows = 5;
  localparam int unsigned RowW    = 5;
  localparam int unsigned KeyW    = 8;
  localparam int unsigned RowIdxW = 3;

  // Register indexes of the configuration port
  localparam logic [0:0] CFG_SAMPLE_DELAY = 1'b0;
  localparam logic [0:0] CFG_BEEP_TICKS   = 1'b1;

  localparam logic [KeyW-1:0] SAMPLE_DELAY_RST = 8'd5;
  localparam logic [KeyW-1:0] BEEP_TICKS_RST   = 8'd2;

  // Reading of a column with exactly one row pulled low, row 0 first
  localparam logic [RowW-1:0] ROW_PAT [NumRows] = '{
    5'h1E, 5'h1D, 5'h1B, 5'h17, 5'h0F
  };

  // Character for [column][row]
  localparam logic [KeyW-1:0] KEY_MAP [NumCols][NumRows] = '{
    '{8'h30, 8'h2E, 8'h50, 8'h2B, 8'h2D},  // '0' '.' 'P' '+' '-'
    '{8'h31, 8'h32, 8'h33, 8'h78, 8'h2F},  // '1' '2' '3' 'x' '/'
    '{8'h34, 8'h35, 8'h36, 8'h3D, 8'h3E},  // '4' '5' '6' '=' '>'
    '{8'h37, 8'h38, 8'h39, 8'h5B, 8'h5D},  // '7' '8' '9' '[' ']'
    '{8'h43, 8'h42, 8'h48, 8'h46, 8'h41}   // 'C' 'B' 'H' 'F' 'A'
  };

  // What one column lane found
  typedef struct packed {
    logic               hit;
    logic [RowIdxW-1:0] row;
  } lane_res_t;

  // One result word, accepted_key in the lowest bits
  typedef struct packed {
    logic [KeyW-1:0] beep_length;
    logic            beep_start;
    logic            key_event;
    logic [KeyW-1:0] accepted_key;
  } kpd_res_t;

endpackage

// ===== rtl/core/kpd_lane.sv =====
// ----------------------------------------------------------------------------
// kpd_lane
// Decodes the row reading of one column: flags a single pressed row and
// gives its index.
// ----------------------------------------------------------------------------
module kpd_lane (
  input  logic [kpd_pkg::RowW-1:0] rows_i,
  output kpd_pkg::lane_res_t       res_o
);

  always_comb begin
    res_o = '0;
    for (int r = 0; r < kpd_pkg::NumRows; r++) begin
      if (rows_i == kpd_pkg::ROW_PAT[r]) begin
        res_o.hit = 1'b1;
        res_o.row = kpd_pkg::RowIdxW'(r);
      end
    end
  end

endmodule

// ===== rtl/core/kpd_merge.sv =====
// ----------------------------------------------------------------------------
// kpd_merge
// Combines the column lanes: the lowest column with a hit selects the key
// character, no hit gives code zero.
// ----------------------------------------------------------------------------
module kpd_merge (
  input  kpd_pkg::lane_res_t          lanes_i [kpd_pkg::NumCols],
  output logic [kpd_pkg::KeyW-1:0]    code_o
);

  always_comb begin
    code_o = '0;
    // walk from the top column down so the lowest hit wins
    for (int c = kpd_pkg::NumCols - 1; c >= 0; c--) begin
      if (lanes_i[c].hit) begin
        code_o = kpd_pkg::KEY_MAP[c][lanes_i[c].row];
      end
    end
  end

endmodule

// ===== rtl/core/matrix_keypad_debounce_decoder_top.sv =====
// ----------------------------------------------------------------------------
// matrix_keypad_debounce_decoder_top
// Keypad scanner: five column lanes decode one tick's readings in parallel,
// a merge picks the key, and a two-sample debounce accepts stable keys.
// Each result word is computed combinationally from its input word and registered in the output buffer.
// Throughput: one word per cycle while s_axis_tready_o is high; the two-entry output buffer keeps input
// open for one more word while a result waits downstream.
// Reset: asynchronous, clears the debounce state and buffer, registers
// return to sample_delay 5 and beep_ticks 2.
// ----------------------------------------------------------------------------
module matrix_keypad_debounce_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // rows_col0..rows_col4 (5b each), zero pad
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o   // accepted_key, key_event, beep_start,
                                       // beep_length, zero pad
);

  localparam int unsigned KeyW = kpd_pkg::KeyW;

  logic [KeyW-1:0] delay_q, beep_q;
  logic [KeyW-1:0] tick_q, tick_d;
  logic            phase_q, phase_d;
  logic [KeyW-1:0] first_q, first_d;
  logic [KeyW-1:0] last_q, last_d;

  kpd_pkg::lane_res_t lanes [kpd_pkg::NumCols];
  logic [KeyW-1:0]    code;

  kpd_pkg::kpd_res_t res, out_q, skid_q;
  logic              out_v_q, skid_v_q;
  logic              push, pop;
  logic [KeyW-1:0]   tick_inc;
  logic              sample, take;

  // column lanes
  for (genvar c = 0; c < kpd_pkg::NumCols; c++) begin : g_lane
    kpd_lane u_lane (
      .rows_i (s_axis_tdata_i[c*kpd_pkg::RowW +: kpd_pkg::RowW]),
      .res_o  (lanes[c])
    );
  end

  kpd_merge u_merge (
    .lanes_i (lanes),
    .code_o  (code)
  );

  assign push = s_axis_tvalid_i & s_axis_tready_o;
  assign pop  = m_axis_tvalid_o & m_axis_tready_i;

  // debounce
  always_comb begin
    tick_inc = tick_q + 8'd1;
    sample   = (tick_inc >= delay_q);
    tick_d   = sample ? '0 : tick_inc;
    phase_d  = phase_q;
    first_d  = first_q;
    last_d   = last_q;
    take     = 1'b0;
    if (sample) begin
      phase_d = ~phase_q;
      if (!phase_q) begin
        first_d = code;
      end else if (code == first_q && code != last_q) begin
        take   = 1'b1;
        last_d = code;
      end
    end
    res.accepted_key = last_d;
    res.key_event    = take & (code != '0);
    res.beep_start   = res.key_event;
    res.beep_length  = res.key_event ? beep_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= kpd_pkg::SAMPLE_DELAY_RST;
      beep_q  <= kpd_pkg::BEEP_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        kpd_pkg::CFG_SAMPLE_DELAY: delay_q <= cfg_wdata_i;
        kpd_pkg::CFG_BEEP_TICKS:   beep_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      phase_q <= 1'b0;
      first_q <= '0;
      last_q  <= '0;
    end else if (push) begin
      tick_q  <= tick_d;
      phase_q <= phase_d;
      first_q <= first_d;
      last_q  <= last_d;
    end
  end

  // two-entry output buffer: head register plus skid
  assign s_axis_tready_o = ~skid_v_q;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {6'b0, out_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!out_v_q || pop) begin
        out_v_q  <= skid_v_q | push;
        skid_v_q <= skid_v_q & push;
      end else if (push) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || pop) begin
      if (skid_v_q) begin
        out_q <= skid_q;
        if (push) skid_q <= res;
      end else if (push) begin
        out_q <= res;
      end
    end else if (push) begin
      skid_q <= res;
    end
  end

  // checks
  a_skid_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held without head entry");

  a_event_has_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.key_event) |-> (out_q.accepted_key != '0 && out_q.beep_start))
    else $error("key event without key or beep");

  a_take_updates_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && take) |=> (last_q == $past(code)))
    else $error("accepted key not stored");

endmodule
